>>> hw/rtl/ttint_pkg.sv
package ttint_pkg;

	// Field widths
	localparam int BOUND_W = 32;
	localparam int N_W     = 21;
	localparam int DEG_W   = 4;
	localparam int RES_W   = 48;

	// Shared long divider: 96-bit dividend, one quotient bit per cycle
	localparam int DIV_W = 96;
	localparam int CNT_W = $clog2(DIV_W);

	localparam logic [63:0] SMAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SMIN64 = 64'h8000_0000_0000_0000;
	localparam logic [63:0] TWO48  = 64'd1 << 48;
	localparam logic [63:0] HALF_Q28 = 64'd1 << 27;

	// |c_k| = round(2^48 / k!), Q.48
	localparam logic [63:0] COEF_MAG [16] = '{
		(TWO48 + 64'd1 / 2) / 64'd1,
		(TWO48 + 64'd1 / 2) / 64'd1,
		(TWO48 + 64'd2 / 2) / 64'd2,
		(TWO48 + 64'd6 / 2) / 64'd6,
		(TWO48 + 64'd24 / 2) / 64'd24,
		(TWO48 + 64'd120 / 2) / 64'd120,
		(TWO48 + 64'd720 / 2) / 64'd720,
		(TWO48 + 64'd5040 / 2) / 64'd5040,
		(TWO48 + 64'd40320 / 2) / 64'd40320,
		(TWO48 + 64'd362880 / 2) / 64'd362880,
		(TWO48 + 64'd3628800 / 2) / 64'd3628800,
		(TWO48 + 64'd39916800 / 2) / 64'd39916800,
		(TWO48 + 64'd479001600 / 2) / 64'd479001600,
		(TWO48 + 64'd6227020800 / 2) / 64'd6227020800,
		(TWO48 + 64'd87178291200 / 2) / 64'd87178291200,
		(TWO48 + 64'd1307674368000 / 2) / 64'd1307674368000
	};

	// sin + cos series: sign is negative for k mod 4 in {2,3}
	function automatic logic [63:0] coef_value(input logic [DEG_W-1:0] k);
		coef_value = k[1] ? (64'd0 - COEF_MAG[k]) : COEF_MAG[k];
	endfunction

	// Sample point select
	localparam logic [1:0] X_INT = 2'd0;
	localparam logic [1:0] X_A   = 2'd1;
	localparam logic [1:0] X_B   = 2'd2;

	// Multiplier operand select
	localparam logic [1:0] MUL_H_LO = 2'd0;
	localparam logic [1:0] MUL_H_HI = 2'd1;
	localparam logic [1:0] MUL_S_LO = 2'd2;
	localparam logic [1:0] MUL_S_HI = 2'd3;

	typedef struct packed {
		logic       load;
		logic       div_start;
		logic       div_scale;
		logic       step_init;
		logic       advance;
		logic       x_load;
		logic [1:0] x_sel;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       horner;
		logic       ends_load;
		logic       ends_add;
		logic       rnd_load;
		logic       rnd_ends;
		logic       sum_add;
		logic       smag_load;
		logic       res_load;
		logic       emit;
	} ttint_cmd_t;

	typedef struct packed {
		logic more_points;
		logic k_last;
		logic div_done;
	} ttint_stat_t;

endpackage

>>> hw/rtl/ttint_div.sv
module ttint_div import ttint_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [N_W-1:0]   divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient,
	output logic [N_W-1:0]   remainder
);

	logic [DIV_W-1:0] num_q;
	logic [N_W-1:0]   rem_q;
	logic [N_W-1:0]   den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [N_W:0] trial;
	logic [N_W:0] diff;
	logic         ge;

	// restoring step: remainder stays below the divisor
	always_comb begin
		trial = {rem_q, num_q[DIV_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[N_W-1:0] : trial[N_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = num_q;
	assign remainder = rem_q;

endmodule

>>> hw/rtl/ttint_datapath.sv
module ttint_datapath import ttint_pkg::*; #(
	parameter int MAX_DEGREE    = 15,
	parameter int MAX_INTERVALS = 1048576
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic signed [BOUND_W-1:0] lower_bound,
	input  logic signed [BOUND_W-1:0] upper_bound,
	input  logic [N_W-1:0]            interval_count,
	input  logic [DEG_W-1:0]          taylor_degree,
	input  ttint_cmd_t                cmd,
	output ttint_stat_t               stat,
	output logic signed [RES_W-1:0]   integral_value,
	output logic                      overflow
);

	function automatic logic [63:0] mag64(input logic [63:0] v);
		mag64 = v[63] ? (64'd0 - v) : v;
	endfunction

	// {overflow, value}
	function automatic logic [64:0] sat_add64(input logic [63:0] x, input logic [63:0] y);
		logic [64:0] s;
		s = {x[63], x} + {y[63], y};
		if (s[64] != s[63])
			sat_add64 = {1'b1, s[64] ? SMIN64 : SMAX64};
		else
			sat_add64 = {1'b0, s[63:0]};
	endfunction

	function automatic logic [64:0] from_mag(input logic [63:0] m, input logic neg);
		if (neg) begin
			if (m[63])
				from_mag = {|m[62:0], SMIN64};
			else
				from_mag = {1'b0, 64'd0 - m};
		end else begin
			if (m[63])
				from_mag = {1'b1, SMAX64};
			else
				from_mag = {1'b0, m};
		end
	endfunction

	// request registers
	logic [BOUND_W-1:0] a_q, b_q;
	logic [N_W-1:0]     n_q;
	logic [DEG_W-1:0]   deg_q;
	logic [32:0]        span_mag_q;
	logic               span_neg_q;

	// point generation: offset = floor(|span| * i / n), tracked incrementally
	logic [32:0]        step_q_q;
	logic [N_W-1:0]     step_r_q;
	logic [32:0]        off_q;
	logic [N_W-1:0]     off_r_q;
	logic [N_W-1:0]     point_index_q;

	// Horner and accumulation
	logic [BOUND_W-1:0] sample_point_q;
	logic [63:0]        horner_partial_q;
	logic [DEG_W-1:0]   k_q;
	logic [63:0]        mlo_q, mhi_q;
	logic [63:0]        ends_q;
	logic [63:0]        rnd_q;
	logic [63:0]        running_sum_q;
	logic [63:0]        smag_q;
	logic               s_neg_q;
	logic               ovf_q;
	logic [67:0]        res_q;
	logic [RES_W-1:0]   integral_value_q;
	logic               overflow_q;

	// divider
	logic [DIV_W-1:0] div_dividend;
	logic             div_done;
	logic [DIV_W-1:0] div_quot;
	logic [N_W-1:0]   div_rem;

	// request clamps
	logic [N_W-1:0]   n_in;
	logic [DEG_W-1:0] deg_in;
	logic [32:0]      span_in;

	always_comb begin
		n_in = (interval_count == '0) ? N_W'(1) : interval_count;
		if ({11'd0, n_in} > 32'(MAX_INTERVALS))
			n_in = N_W'(MAX_INTERVALS);
		deg_in = (taylor_degree == '0) ? DEG_W'(1) : taylor_degree;
		if ({1'b0, deg_in} > 5'(MAX_DEGREE))
			deg_in = DEG_W'(MAX_DEGREE);
		span_in = {upper_bound[BOUND_W-1], upper_bound} - {lower_bound[BOUND_W-1], lower_bound};
	end

	// next offset
	logic [N_W:0] rs, rs_sub;
	logic         wrap;

	always_comb begin
		rs     = {1'b0, off_r_q} + {1'b0, step_r_q};
		rs_sub = rs - {1'b0, n_q};
		wrap   = (rs >= {1'b0, n_q});
	end

	logic [BOUND_W-1:0] x_next;

	always_comb begin
		case (cmd.x_sel)
			X_INT:   x_next = span_neg_q ? (a_q - off_q[31:0]) : (a_q + off_q[31:0]);
			X_A:     x_next = a_q;
			X_B:     x_next = b_q;
			default: x_next = a_q;
		endcase
	end

	// shared 32x32 multiplier
	logic [63:0] pm;
	logic [31:0] xm;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	always_comb begin
		pm = mag64(horner_partial_q);
		xm = sample_point_q[31] ? (32'd0 - sample_point_q) : sample_point_q;
		case (cmd.mul_sel)
			MUL_H_LO: begin
				mul_a = pm[31:0];
				mul_b = xm;
			end
			MUL_H_HI: begin
				mul_a = pm[63:32];
				mul_b = xm;
			end
			MUL_S_LO: begin
				mul_a = smag_q[31:0];
				mul_b = span_mag_q[31:0];
			end
			MUL_S_HI: begin
				mul_a = smag_q[63:32];
				mul_b = span_mag_q[31:0];
			end
			default: begin
				mul_a = pm[31:0];
				mul_b = xm;
			end
		endcase
		mul_p = {32'd0, mul_a} * {32'd0, mul_b};
	end

	// Horner combine: product to Q.48 with rounding, then add coefficient
	logic [63:0] lo_r, hm;
	logic        hneg;
	logic [64:0] hprod, hnext;
	logic        hovf;

	always_comb begin
		lo_r = mlo_q + HALF_Q28;
		hm   = {mhi_q[59:0], 4'd0} + {28'd0, lo_r[63:28]};
		hneg = horner_partial_q[63] ^ sample_point_q[31];
		if (|mhi_q[63:59])
			hprod = {1'b1, hneg ? SMIN64 : SMAX64};
		else
			hprod = from_mag(hm, hneg);
		hnext = sat_add64(hprod[63:0], coef_value(k_q - DEG_W'(1)));
		hovf  = hprod[64] | hnext[64];
	end

	// rounding to Q.32 (interior: >>16, endpoints with the half: >>17)
	logic [63:0] rsrc, rm, rr, rval;

	always_comb begin
		rsrc = cmd.rnd_ends ? ends_q : horner_partial_q;
		rm   = mag64(rsrc);
		if (cmd.rnd_ends)
			rr = {17'd0, rm[63:17]} + {63'd0, rm[16]};
		else
			rr = {16'd0, rm[63:16]} + {63'd0, rm[15]};
		rval = rsrc[63] ? (64'd0 - rr) : rr;
	end

	logic [64:0] sum_next, ends_next;

	always_comb begin
		sum_next  = sat_add64(running_sum_q, rnd_q);
		ends_next = sat_add64(ends_q, horner_partial_q);
	end

	always_comb begin
		if (cmd.div_scale)
			div_dividend = {32'd0, mlo_q} + {mhi_q, 32'd0}
				+ (span_mag_q[32] ? {smag_q, 32'd0} : {DIV_W{1'b0}});
		else
			div_dividend = {63'd0, span_mag_q};
	end

	// final sign and 48-bit saturation
	logic             rneg;
	logic [RES_W-1:0] fin_val;
	logic             fin_ovf;

	always_comb begin
		rneg    = s_neg_q ^ span_neg_q;
		fin_ovf = 1'b0;
		if (rneg) begin
			if (res_q > (68'd1 << 47)) begin
				fin_ovf = 1'b1;
				fin_val = {1'b1, {(RES_W-1){1'b0}}};
			end else begin
				fin_val = {RES_W{1'b0}} - res_q[RES_W-1:0];
			end
		end else begin
			if (res_q > ((68'd1 << 47) - 68'd1)) begin
				fin_ovf = 1'b1;
				fin_val = {1'b0, {(RES_W-1){1'b1}}};
			end else begin
				fin_val = res_q[RES_W-1:0];
			end
		end
	end

	ttint_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (n_q),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q        <= lower_bound;
			b_q        <= upper_bound;
			n_q        <= n_in;
			deg_q      <= deg_in;
			span_neg_q <= span_in[32];
			span_mag_q <= span_in[32] ? (33'd0 - span_in) : span_in;
		end

		if (cmd.step_init) begin
			step_q_q      <= div_quot[32:0];
			step_r_q      <= div_rem;
			off_q         <= '0;
			off_r_q       <= '0;
			point_index_q <= '0;
		end else if (cmd.advance) begin
			off_q         <= off_q + step_q_q + {32'd0, wrap};
			off_r_q       <= wrap ? rs_sub[N_W-1:0] : rs[N_W-1:0];
			point_index_q <= point_index_q + N_W'(1);
		end

		if (cmd.x_load) begin
			sample_point_q   <= x_next;
			horner_partial_q <= coef_value(deg_q);
			k_q              <= deg_q;
		end else if (cmd.horner) begin
			horner_partial_q <= hnext[63:0];
			k_q              <= k_q - DEG_W'(1);
		end

		if (cmd.mul_en) begin
			if (cmd.mul_sel == MUL_H_HI || cmd.mul_sel == MUL_S_HI)
				mhi_q <= mul_p;
			else
				mlo_q <= mul_p;
		end

		if (cmd.ends_load)
			ends_q <= horner_partial_q;
		else if (cmd.ends_add)
			ends_q <= ends_next[63:0];

		if (cmd.rnd_load)
			rnd_q <= rval;

		if (cmd.step_init)
			running_sum_q <= '0;
		else if (cmd.sum_add)
			running_sum_q <= sum_next[63:0];

		if (cmd.step_init)
			ovf_q <= 1'b0;
		else if (cmd.horner)
			ovf_q <= ovf_q | hovf;
		else if (cmd.ends_add)
			ovf_q <= ovf_q | ends_next[64];
		else if (cmd.sum_add)
			ovf_q <= ovf_q | sum_next[64];

		if (cmd.smag_load) begin
			smag_q  <= mag64(running_sum_q);
			s_neg_q <= running_sum_q[63];
		end

		if (cmd.res_load)
			res_q <= div_quot[DIV_W-1:28] + {67'd0, div_quot[27]};

		if (cmd.emit) begin
			integral_value_q <= fin_val;
			overflow_q       <= ovf_q | fin_ovf;
		end
	end

	always_comb begin
		stat.more_points = (({1'b0, point_index_q} + 22'd1) < {1'b0, n_q});
		stat.k_last      = (k_q == DEG_W'(1));
		stat.div_done    = div_done;
	end

	assign integral_value = integral_value_q;
	assign overflow       = overflow_q;

endmodule

>>> hw/rtl/ttint_ctrl.sv
module ttint_ctrl import ttint_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        request_valid,
	output logic        request_stall,
	output logic        result_valid,
	input  logic        result_stall,
	input  ttint_stat_t stat,
	output ttint_cmd_t  cmd
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DIV0  = 5'd1;
	localparam logic [4:0] S_DIVW  = 5'd2;
	localparam logic [4:0] S_NEXT  = 5'd3;
	localparam logic [4:0] S_LOADX = 5'd4;
	localparam logic [4:0] S_HLO   = 5'd5;
	localparam logic [4:0] S_HHI   = 5'd6;
	localparam logic [4:0] S_HCMB  = 5'd7;
	localparam logic [4:0] S_ENDS  = 5'd8;
	localparam logic [4:0] S_RND   = 5'd9;
	localparam logic [4:0] S_SADD  = 5'd10;
	localparam logic [4:0] S_SMAG  = 5'd11;
	localparam logic [4:0] S_SLO   = 5'd12;
	localparam logic [4:0] S_SHI   = 5'd13;
	localparam logic [4:0] S_DIV1  = 5'd14;
	localparam logic [4:0] S_DIVW2 = 5'd15;
	localparam logic [4:0] S_FIN   = 5'd16;

	localparam logic [1:0] PH_INT = 2'd0;
	localparam logic [1:0] PH_A   = 2'd1;
	localparam logic [1:0] PH_B   = 2'd2;

	logic [4:0] state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !result_stall;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (request_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DIV0;
				end
			end
			S_DIV0: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIVW;
			end
			S_DIVW: begin
				if (stat.div_done) begin
					cmd.step_init = 1'b1;
					phase_d       = PH_INT;
					state_d       = S_NEXT;
				end
			end
			S_NEXT: begin
				if (stat.more_points)
					cmd.advance = 1'b1;
				else
					phase_d = PH_A;
				state_d = S_LOADX;
			end
			S_LOADX: begin
				cmd.x_load = 1'b1;
				case (phase_q)
					PH_A:    cmd.x_sel = X_A;
					PH_B:    cmd.x_sel = X_B;
					default: cmd.x_sel = X_INT;
				endcase
				state_d = S_HLO;
			end
			S_HLO: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_H_LO;
				state_d     = S_HHI;
			end
			S_HHI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_H_HI;
				state_d     = S_HCMB;
			end
			S_HCMB: begin
				cmd.horner = 1'b1;
				if (!stat.k_last)
					state_d = S_HLO;
				else if (phase_q == PH_INT)
					state_d = S_RND;
				else
					state_d = S_ENDS;
			end
			S_ENDS: begin
				if (phase_q == PH_A) begin
					cmd.ends_load = 1'b1;
					phase_d       = PH_B;
					state_d       = S_LOADX;
				end else begin
					cmd.ends_add = 1'b1;
					state_d      = S_RND;
				end
			end
			S_RND: begin
				cmd.rnd_load = 1'b1;
				cmd.rnd_ends = (phase_q == PH_B);
				state_d      = S_SADD;
			end
			S_SADD: begin
				cmd.sum_add = 1'b1;
				state_d     = (phase_q == PH_B) ? S_SMAG : S_NEXT;
			end
			S_SMAG: begin
				cmd.smag_load = 1'b1;
				state_d       = S_SLO;
			end
			S_SLO: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_S_LO;
				state_d     = S_SHI;
			end
			S_SHI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_S_HI;
				state_d     = S_DIV1;
			end
			S_DIV1: begin
				cmd.div_start = 1'b1;
				cmd.div_scale = 1'b1;
				state_d       = S_DIVW2;
			end
			S_DIVW2: begin
				if (stat.div_done) begin
					cmd.res_load = 1'b1;
					state_d      = S_FIN;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_INT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign request_stall = (state_q != S_IDLE);
	assign result_valid  = out_valid_q;

endmodule

>>> hw/rtl/taylor_trapezoid_integrator.sv
// Each Horner multiply-add (lo product, hi product, combine) uses the single 32x32
//   multiplier, and the bit-serial divider runs twice (step size, final scale by 1/N).
// Throughput: one request at a time; the next is taken once the previous result
//   sits in the output register, so a held result does not block a new request.
// Reset: arst_n asynchronous, active low; clears the controller, divider and result valid.
module taylor_trapezoid_integrator import ttint_pkg::*; #(
	parameter int MAX_DEGREE    = 15,
	parameter int MAX_INTERVALS = 1048576
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// request channel
	input  logic                      request_valid,
	output logic                      request_stall,
	input  logic signed [BOUND_W-1:0] lower_bound,
	input  logic signed [BOUND_W-1:0] upper_bound,
	input  logic [N_W-1:0]            interval_count,
	input  logic [DEG_W-1:0]          taylor_degree,
	// result channel
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic signed [RES_W-1:0]   integral_value,
	output logic                      overflow
);

	// Controller sequences one request:
	//   1. latch and clamp the request, |b-a| / N on the divider (quotient and
	//      remainder drive an exact running offset floor(|b-a|*i/N))
	//   2. for each interior point: step the offset, form x, run Horner
	//      (lo product, hi product, round/saturate/add coefficient), round to
	//      Q.32 and accumulate
	//   3. P(a) and P(b) go through the same Horner loop, summed in Q.48,
	//      halved and rounded into the running sum
	//   4. |sum| * |b-a| in two multiplier passes, divided by N, rounded to
	//      Q.32, sign applied and saturated to 48 bits
	// The datapath owns every arithmetic register; the controller only issues
	// commands and watches status (points left, last Horner step, divider done).
	ttint_cmd_t  cmd;
	ttint_stat_t stat;

	ttint_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.request_stall (request_stall),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.stat          (stat),
		.cmd           (cmd)
	);

	// Saturation anywhere along the way is sticky in the datapath and reported
	// with the result through the overflow output.
	ttint_datapath #(
		.MAX_DEGREE    (MAX_DEGREE),
		.MAX_INTERVALS (MAX_INTERVALS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.lower_bound    (lower_bound),
		.upper_bound    (upper_bound),
		.interval_count (interval_count),
		.taylor_degree  (taylor_degree),
		.cmd            (cmd),
		.stat           (stat),
		.integral_value (integral_value),
		.overflow       (overflow)
	);

endmodule

>>> tb/taylor_trapezoid_integrator_tb.sv
`timescale 1ns / 1ps

module taylor_trapezoid_integrator_tb import ttint_pkg::*;;

	localparam int     HALF_PERIOD  = 4;
	localparam int     DEGREE_CAP   = 15;
	localparam int     INTERVAL_CAP = 1048576;
	localparam int     RANDOM_COUNT = 75;
	// Slowest correct run is the one request at the interval clamp at degree 1; the limit
	// is several times that run and everything else together.
	localparam longint CYCLE_LIMIT  = 40_000_000;
	// Receiver backs up for this long once this many results are in
	localparam int     BACKUP_AT    = 35;
	localparam int     BACKUP_LEN   = 5000;
	localparam int     TAIL_CYCLES  = 400;

	localparam logic [63:0] TOP_BIT   = 64'h8000_0000_0000_0000;
	localparam logic [63:0] POS_MAG   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam longint      POS_LIMIT = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint      NEG_LIMIT = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic signed [BOUND_W-1:0] lower;
		logic signed [BOUND_W-1:0] upper;
		logic [N_W-1:0]            count;
		logic [DEG_W-1:0]          degree;
		bit                        drain_first; // hold until every result is back
		bit                        calm;        // no gap after this request
	} request_t;

	typedef struct packed {
		logic signed [RES_W-1:0] value;
		logic                    ovf;
	} integral_t;

	logic                      clk            = 1'b0;
	logic                      arst_n         = 1'b0;
	logic                      request_valid  = 1'b0;
	logic                      request_stall;
	logic signed [BOUND_W-1:0] lower_bound    = '0;
	logic signed [BOUND_W-1:0] upper_bound    = '0;
	logic [N_W-1:0]            interval_count = '0;
	logic [DEG_W-1:0]          taylor_degree  = '0;
	logic                      result_valid;
	logic                      result_stall   = 1'b0;
	logic signed [RES_W-1:0]   integral_value;
	logic                      overflow;

	request_t  request_backlog[$];
	integral_t expected_integrals[$];
	longint    coef_table[DEGREE_CAP + 1];

	request_t    on_offer;
	bit          offering;
	int unsigned send_gap;
	int          request_total;
	int          requests_accepted;

	integral_t   want;
	int unsigned hold_left;
	int unsigned stall_left;
	int unsigned calm_left;
	bit          backup_done;
	int          results_checked;
	int          saturated_seen;
	int          mismatches;
	longint      cycle_count;

	taylor_trapezoid_integrator DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.request_valid  (request_valid),
		.request_stall  (request_stall),
		.lower_bound    (lower_bound),
		.upper_bound    (upper_bound),
		.interval_count (interval_count),
		.taylor_degree  (taylor_degree),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.integral_value (integral_value),
		.overflow       (overflow)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ---------------------------------------------------------------
	// Integral predictor, 64-bit fixed point with sticky saturation
	// ---------------------------------------------------------------

	function automatic logic [63:0] magnitude(input longint v);
		logic [63:0] u;
		u = v;
		return v[63] ? ~u + 64'd1 : u;
	endfunction

	function automatic longint signed_from_mag(input logic [63:0] m, input bit neg,
			inout bit ovf);
		if (neg) begin
			if (m >= TOP_BIT) begin
				if (m > TOP_BIT)
					ovf = 1'b1;
				return NEG_LIMIT;
			end
			return -longint'(m);
		end
		if (m > POS_MAG) begin
			ovf = 1'b1;
			return POS_LIMIT;
		end
		return longint'(m);
	endfunction

	function automatic longint add_clamped(input longint x, input longint y, inout bit ovf);
		logic [64:0] s;
		s = {x[63], x} + {y[63], y};
		// top two bits disagree: the 64-bit sum wrapped
		if (!s[64] && s[63]) begin
			ovf = 1'b1;
			return POS_LIMIT;
		end
		if (s[64] && !s[63]) begin
			ovf = 1'b1;
			return NEG_LIMIT;
		end
		return longint'(s[63:0]);
	endfunction

	// drop sh bits, round half away from zero
	function automatic longint round_away(input longint v, input int unsigned sh);
		logic [63:0] m;
		bit          ignored;
		m = magnitude(v);
		m = (m >> sh) + ((m >> (sh - 1)) & 64'd1);
		ignored = 1'b0;
		return signed_from_mag(m, v < 0, ignored);
	endfunction

	// Q.48 times Q3.28 back to Q.48
	function automatic longint horner_product(input longint p, input longint x, inout bit ovf);
		logic [63:0] pm, xm, lo, hi;
		bit          neg;
		pm  = magnitude(p);
		xm  = magnitude(x);
		lo  = (pm & 64'hFFFF_FFFF) * xm + (64'd1 << 27);
		hi  = (pm >> 32) * xm;
		neg = (p < 0) != (x < 0);
		if (hi >= (64'd1 << 59)) begin
			ovf = 1'b1;
			return neg ? NEG_LIMIT : POS_LIMIT;
		end
		return signed_from_mag((hi << 4) + (lo >> 28), neg, ovf);
	endfunction

	// +-1/k! in Q.48; sign follows sin+cos: minus for k mod 4 of 2 or 3
	function automatic longint series_coef(input int unsigned k);
		logic [63:0] f, m;
		int unsigned j;
		f = 64'd1;
		if (k > 17)
			return 0;
		for (j = 2; j <= k; j++)
			f = f * j;
		m = ((64'd1 << 48) + f / 2) / f;
		return (k % 4 >= 2) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint taylor_eval(input longint x, input int unsigned deg,
			inout bit ovf);
		longint acc;
		int     k;
		acc = coef_table[deg];
		for (k = int'(deg) - 1; k >= 0; k--)
			acc = add_clamped(horner_product(acc, x, ovf), coef_table[k], ovf);
		return acc;
	endfunction

	// round(floor(|S*(b-a)| / N) / 2^28), sign back on, clamp to 48 bits
	function automatic longint scale_by_step(input longint s, input longint d,
			input logic [63:0] n, inout bit ovf);
		logic [127:0] prod, q;
		logic [63:0]  r;
		bit           neg;
		prod = {64'd0, magnitude(s)} * {64'd0, magnitude(d)};
		q    = prod / {64'd0, n};
		neg  = (s < 0) != (d < 0);
		if (q >= (128'd1 << 91))
			r = TOP_BIT;
		else
			r = q[91:28] + {63'd0, q[27]};
		if (neg) begin
			if (r > (64'd1 << 47)) begin
				ovf = 1'b1;
				r   = 64'd1 << 47;
			end
			return -longint'(r);
		end
		if (r > (64'd1 << 47) - 64'd1) begin
			ovf = 1'b1;
			r   = (64'd1 << 47) - 64'd1;
		end
		return longint'(r);
	endfunction

	function automatic integral_t integrate_request(input request_t rq);
		longint      a, b, span, acc, ends;
		int          point;
		logic [63:0] n, i, q, span_mag;
		int unsigned deg;
		bit          ovf;
		integral_t   res;
		a   = longint'(rq.lower);
		b   = longint'(rq.upper);
		n   = {43'd0, rq.count};
		deg = {28'd0, rq.degree};
		// out-of-range count and degree clamp rather than fault
		if (n < 64'd1)
			n = 64'd1;
		if (n > INTERVAL_CAP)
			n = 64'(INTERVAL_CAP);
		if (deg < 1)
			deg = 1;
		if (deg > DEGREE_CAP)
			deg = DEGREE_CAP;
		ovf      = 1'b0;
		span     = b - a;
		span_mag = magnitude(span);
		acc      = 0;
		// interior points, each exact to one Q3.28 step
		for (i = 64'd1; i < n; i++) begin
			q     = span_mag * i / n;
			point = int'(span < 0 ? a - longint'(q) : a + longint'(q));
			acc   = add_clamped(acc, round_away(taylor_eval(longint'(point), deg, ovf), 16),
				ovf);
		end
		// endpoints at half weight: one extra bit in the shift
		ends      = add_clamped(taylor_eval(a, deg, ovf), taylor_eval(b, deg, ovf), ovf);
		acc       = add_clamped(acc, round_away(ends, 17), ovf);
		res.value = RES_W'(scale_by_step(acc, span, n, ovf));
		res.ovf   = ovf;
		return res;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	task automatic queue_request(input logic signed [BOUND_W-1:0] lo,
			input logic signed [BOUND_W-1:0] hi, input logic [N_W-1:0] cnt,
			input logic [DEG_W-1:0] deg, input bit drain, input bit calm);
		request_t rq;
		rq.lower       = lo;
		rq.upper       = hi;
		rq.count       = cnt;
		rq.degree      = deg;
		rq.drain_first = drain;
		rq.calm        = calm;
		request_backlog.push_back(rq);
	endtask

	// half the time none, often a short gap, now and then a long gap
	function automatic int unsigned pick_idle();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(15, 80);
	endfunction

	// ---------------------------------------------------------------
	// Request driver: predicts at acceptance, then offers the next one
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_valid  <= 1'b0;
			lower_bound    <= '0;
			upper_bound    <= '0;
			interval_count <= '0;
			taylor_degree  <= '0;
			send_gap       = 0;
		end else begin
			offering = request_valid;
			if (request_valid && !request_stall) begin
				expected_integrals.push_back(integrate_request(on_offer));
				requests_accepted++;
				offering = 1'b0;
				send_gap = on_offer.calm ? 0 : pick_idle();
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (request_backlog.size() > 0 &&
						!(request_backlog[0].drain_first && expected_integrals.size() > 0)) begin
					on_offer       = request_backlog.pop_front();
					lower_bound    <= on_offer.lower;
					upper_bound    <= on_offer.upper;
					interval_count <= on_offer.count;
					taylor_degree  <= on_offer.degree;
					offering       = 1'b1;
				end
			end
			// single update per edge, so a back-to-back request keeps valid high
			request_valid <= offering;
		end
	end

	// ---------------------------------------------------------------
	// Result monitor and receiver stall pattern
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left    = 0;
			stall_left   = 0;
			calm_left    = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_integrals.size() == 0) begin
					$display("%0t: result with no request pending: value %0d overflow %0b",
						$time, integral_value, overflow);
					mismatches++;
				end else begin
					want = expected_integrals.pop_front();
					if (integral_value !== want.value) begin
						$display("%0t: integral_value expected %0d actual %0d",
							$time, want.value, integral_value);
						mismatches++;
					end
					if (overflow !== want.ovf) begin
						$display("%0t: overflow expected %0b actual %0b",
							$time, want.ovf, overflow);
						mismatches++;
					end
					if (want.ovf)
						saturated_seen++;
					results_checked++;
				end
				// one long back-up while the sender keeps offering: fills the block
				if (results_checked == BACKUP_AT && !backup_done) begin
					hold_left   = BACKUP_LEN;
					backup_done = 1'b1;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (calm_left > 0) begin
				calm_left--;
				result_stall <= 1'b0;
			end else begin
				result_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0)
					calm_left = $urandom_range(100, 600);
				else
					stall_left = pick_idle();
			end
		end
	end

	// ---------------------------------------------------------------
	// Run limit
	// ---------------------------------------------------------------
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, expected_integrals.size());
		$display("FAILED: results differ");
		$finish;
	end

	// ---------------------------------------------------------------
	// Stimulus and end of run
	// ---------------------------------------------------------------
	initial begin
		int                        r, d, roll;
		logic signed [BOUND_W-1:0] lo, hi;
		logic [N_W-1:0]            cnt;

		foreach (coef_table[k])
			coef_table[k] = series_coef(k);

		// directed: zero span, full range both ways, ends only, equal bounds
		queue_request(32'h0000_0000, 32'h0000_0000, N_W'(1), DEG_W'(1), 1'b0, 1'b0);
		queue_request(32'h8000_0000, 32'h7FFF_FFFF, N_W'(16), DEG_W'(15), 1'b0, 1'b0);
		queue_request(32'h7FFF_FFFF, 32'h8000_0000, N_W'(16), DEG_W'(15), 1'b0, 1'b0);
		queue_request(32'h8000_0000, 32'h7FFF_FFFF, N_W'(16), DEG_W'(14), 1'b0, 1'b0);
		queue_request(32'h8000_0000, 32'h7FFF_FFFF, N_W'(1), DEG_W'(13), 1'b0, 1'b0);
		queue_request(32'h8000_0000, 32'h8000_0000, N_W'(5), DEG_W'(15), 1'b0, 1'b0);
		// interval count zero, degree zero
		queue_request(32'hF000_0000, 32'h1000_0000, N_W'(0), DEG_W'(6), 1'b0, 1'b0);
		queue_request(32'hF000_0000, 32'h1000_0000, N_W'(4), DEG_W'(0), 1'b0, 1'b0);
		// every degree over [-2, 2]
		for (d = 0; d <= DEGREE_CAP; d++)
			queue_request(32'hE000_0000, 32'h2000_0000, N_W'(d + 1), DEG_W'(d), 1'b0, 1'b0);
		// count above the clamp with all bits set; degree zero keeps the clamped run short
		queue_request(32'h8000_0000, 32'h7FFF_FFFF, 21'h1F_FFFF, DEG_W'(0), 1'b1, 1'b1);

		// random: mostly short interval counts, some wider, a few odd ones
		for (r = 0; r < RANDOM_COUNT; r++) begin
			lo   = $urandom;
			hi   = $urandom;
			roll = $urandom_range(0, 9);
			if (roll < 3)
				hi = lo + BOUND_W'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
			else if (roll == 3)
				hi = lo;
			roll = $urandom_range(0, 19);
			if (roll < 14)
				cnt = N_W'($urandom_range(1, 8));
			else if (roll < 19)
				cnt = N_W'($urandom_range(9, 64));
			else
				cnt = ($urandom_range(0, 1) == 0) ? '0 : N_W'($urandom_range(65, 200));
			queue_request(lo, hi, cnt, DEG_W'($urandom_range(0, 15)),
				r % 25 == 0, (r / 10) % 3 == 1);
		end
		request_total = request_backlog.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (requests_accepted < request_total || expected_integrals.size() > 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("%0d requests integrated, %0d results checked, %0d flagged saturated",
			request_total, results_checked, saturated_seen);
		$display("degrees 0..15, counts 0..clamp, reversed/equal bounds, long output back-up");
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/ttint_pkg.sv
hw/rtl/ttint_div.sv
hw/rtl/ttint_datapath.sv
hw/rtl/ttint_ctrl.sv
hw/rtl/taylor_trapezoid_integrator.sv
tb/taylor_trapezoid_integrator_tb.sv
